### src/pip_sub_pkg.sv
`timescale 1ns / 1ps
package pip_sub_pkg;

   localparam int DEPTH       = 1024;
   localparam int SAMPLE_BITS = 16;

   // Widths fixed by the register and result formats.
   localparam int WIN_W  = 11;
   localparam int PER_W  = 16;
   localparam int AREA_W = 52;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 5;
   localparam int REG_IDX_W = 3;

   // Derived widths.
   localparam int IDX_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (IDX_W > WIN_W) ? IDX_W : WIN_W;
   localparam int LEN_W  = WIN_W;
   localparam int ACC_W  = SAMPLE_BITS + $clog2(DEPTH) + 1;
   localparam int PROD_W = ACC_W + LEN_W + 1;
   localparam int MAG_W  = PROD_W;
   localparam int SCL_W  = MAG_W + PER_W;
   localparam int CNT_W  = $clog2(SCL_W);

   localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(PER_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(SCL_W - 1);

   localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);
   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

   localparam logic [REG_IDX_W-1:0] REG_INTEG_START = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_INTEG_STOP  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PED_START   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PED_STOP    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_PERIOD      = 3'd4;

   localparam logic [WIN_W-1:0] INTEG_STOP_RST = 11'd1024;
   localparam logic [PER_W-1:0] PERIOD_RST     = 16'd500;

   typedef struct packed {
      logic [WIN_W-1:0] integ_start;
      logic [WIN_W-1:0] integ_stop;
      logic [WIN_W-1:0] ped_start;
      logic [WIN_W-1:0] ped_stop;
      logic [PER_W-1:0] sample_period_ps;
   } cfg_type;

   typedef struct packed {
      logic acc;
      logic mul;
      logic diff;
      logic scale_step;
      logic div_step;
      logic emit;
   } cmd_type;

endpackage

### src/pip_sub_csr.sv
`timescale 1ns / 1ps
module pip_sub_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pip_sub_pkg::ADDR_W-1:0]    paddr,
   input  logic [pip_sub_pkg::DATA_W-1:0]    pwdata,
   output logic [pip_sub_pkg::DATA_W-1:0]    prdata,
   output logic                              pready,
   output pip_sub_pkg::cfg_type              cfg
);
   import pip_sub_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic wr_en;

   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_INTEG_START: cfg_in.integ_start      = pwdata[WIN_W-1:0];
            REG_INTEG_STOP:  cfg_in.integ_stop       = pwdata[WIN_W-1:0];
            REG_PED_START:   cfg_in.ped_start        = pwdata[WIN_W-1:0];
            REG_PED_STOP:    cfg_in.ped_stop         = pwdata[WIN_W-1:0];
            REG_PERIOD:      cfg_in.sample_period_ps = pwdata[PER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_INTEG_START: prdata = DATA_W'(cfg_ff.integ_start);
         REG_INTEG_STOP:  prdata = DATA_W'(cfg_ff.integ_stop);
         REG_PED_START:   prdata = DATA_W'(cfg_ff.ped_start);
         REG_PED_STOP:    prdata = DATA_W'(cfg_ff.ped_stop);
         REG_PERIOD:      prdata = DATA_W'(cfg_ff.sample_period_ps);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.integ_start      <= '0;
         cfg_ff.integ_stop       <= INTEG_STOP_RST;
         cfg_ff.ped_start        <= '0;
         cfg_ff.ped_stop         <= '0;
         cfg_ff.sample_period_ps <= PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/pip_sub_ctrl.sv
`timescale 1ns / 1ps
module pip_sub_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_last_sample,
   input  logic                 use_ped,
   output logic                 busy,
   output pip_sub_pkg::cmd_type cmd
);
   import pip_sub_pkg::*;

   typedef enum logic [2:0] {
      S_RUN,
      S_MULT,
      S_DIFF,
      S_SCALE,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic accept;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_RUN: begin
            if (accept && req_last_sample) state_in = S_MULT;
         end
         S_MULT: begin
            state_in = S_DIFF;
         end
         S_DIFF: begin
            state_in = S_SCALE;
            cnt_in   = '0;
         end
         S_SCALE: begin
            if (cnt_ff == SCALE_LAST) begin
               cnt_in   = '0;
               state_in = use_ped ? S_DIV : S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DIV: begin
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            state_in = S_RUN;
         end
         default: state_in = S_RUN;
      endcase
      busy_in = (state_in != S_RUN);
   end

   always_comb begin
      cmd            = '0;
      cmd.acc        = accept;
      cmd.mul        = (state_ff == S_MULT);
      cmd.diff       = (state_ff == S_DIFF);
      cmd.scale_step = (state_ff == S_SCALE);
      cmd.div_step   = (state_ff == S_DIV);
      cmd.emit       = (state_ff == S_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
         cnt_ff   <= '0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         busy_ff  <= busy_in;
      end
   end

`ifndef SYNTHESIS
   // The final item of a waveform must lock out the input until the result is out.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_sample) |=> busy)
      else $error("busy not raised after the final item");

   // The divider only runs when there is a pedestal length to divide by.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> use_ped)
      else $error("divide step without pedestal");

   // The input opens again in the cycle that shows the result.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !busy)
      else $error("busy still high while the result is shown");
`endif

endmodule

### src/pip_sub_dp.sv
`timescale 1ns / 1ps
module pip_sub_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pip_sub_pkg::cfg_type                   cfg,
   input  pip_sub_pkg::cmd_type                   cmd,
   input  logic signed [pip_sub_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                   use_ped,
   output logic                                   rsp_valid,
   output logic signed [pip_sub_pkg::AREA_W-1:0]  rsp_pulse_area,
   output logic                                   rsp_pedestal_used
);
   import pip_sub_pkg::*;

   function automatic logic [CMP_W-1:0] clamp_stop(input logic [WIN_W-1:0] stop);
      logic [CMP_W-1:0] s;
      s = CMP_W'(stop);
      return (s > DEPTH_CMP) ? DEPTH_CMP : s;
   endfunction

   function automatic logic [LEN_W-1:0] win_len(input logic [WIN_W-1:0] start_v,
                                                input logic [WIN_W-1:0] stop_v);
      logic [CMP_W-1:0] s;
      logic [CMP_W-1:0] b;
      s = clamp_stop(stop_v);
      b = CMP_W'(start_v);
      return (s > b) ? LEN_W'(s - b) : '0;
   endfunction

   logic [IDX_W-1:0]        sample_index_ff, sample_index_in;
   logic signed [ACC_W-1:0] integ_accum_ff, integ_accum_in;
   logic signed [ACC_W-1:0] ped_accum_ff, ped_accum_in;

   logic signed [PROD_W-1:0] prod_a_ff, prod_b_ff;
   logic signed [PROD_W-1:0] diff_w;
   logic [MAG_W-1:0]         mag_w, mag_ff;
   logic                     neg_ff;
   logic [SCL_W-1:0]         work_ff;
   logic [PER_W-1:0]         per_sh_ff;
   logic [LEN_W-1:0]         rem_ff;
   logic [LEN_W:0]           rem_sh;
   logic                     q_bit;

   logic [CMP_W-1:0] idx_x;
   logic             in_integ, in_ped;
   logic [LEN_W-1:0] integ_len, ped_len;
   logic signed [ACC_W-1:0] x_ext;

   logic                     over;
   logic signed [AREA_W-1:0] area_w;
   logic                     rsp_valid_ff;
   logic signed [AREA_W-1:0] rsp_pulse_area_ff;
   logic                     rsp_pedestal_used_ff;

   assign idx_x     = CMP_W'(sample_index_ff);
   assign in_integ  = (idx_x >= CMP_W'(cfg.integ_start)) && (idx_x < clamp_stop(cfg.integ_stop));
   assign in_ped    = (idx_x >= CMP_W'(cfg.ped_start)) && (idx_x < clamp_stop(cfg.ped_stop));
   assign integ_len = win_len(cfg.integ_start, cfg.integ_stop);
   assign ped_len   = win_len(cfg.ped_start, cfg.ped_stop);
   // A nonempty pedestal window always has start below stop.
   assign use_ped   = (ped_len != '0);
   assign x_ext     = ACC_W'(req_sample);

   always_comb begin
      sample_index_in = sample_index_ff;
      integ_accum_in  = integ_accum_ff;
      ped_accum_in    = ped_accum_ff;
      if (cmd.emit) begin
         sample_index_in = '0;
         integ_accum_in  = '0;
         ped_accum_in    = '0;
      end else if (cmd.acc && (sample_index_ff < DEPTH_IDX)) begin
         if (in_integ) integ_accum_in = integ_accum_ff + x_ext;
         if (in_ped)   ped_accum_in   = ped_accum_ff + x_ext;
         sample_index_in = sample_index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
         integ_accum_ff  <= '0;
         ped_accum_ff    <= '0;
      end else begin
         sample_index_ff <= sample_index_in;
         integ_accum_ff  <= integ_accum_in;
         ped_accum_ff    <= ped_accum_in;
      end
   end

   // Cross products of the two sums with the opposite window lengths.
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_a_ff <= integ_accum_ff * $signed({1'b0, ped_len});
         prod_b_ff <= ped_accum_ff * $signed({1'b0, integ_len});
      end
   end

   assign diff_w = use_ped ? (prod_a_ff - prod_b_ff) : PROD_W'(integ_accum_ff);
   assign mag_w  = diff_w[PROD_W-1] ? $unsigned(-diff_w) : $unsigned(diff_w);

   // Restoring division step: the quotient bits shift into the work register.
   assign rem_sh = {rem_ff, work_ff[SCL_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, ped_len});

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         mag_ff    <= mag_w;
         neg_ff    <= diff_w[PROD_W-1];
         work_ff   <= '0;
         per_sh_ff <= cfg.sample_period_ps;
         rem_ff    <= '0;
      end else if (cmd.scale_step) begin
         work_ff   <= {work_ff[SCL_W-2:0], 1'b0}
                      + (per_sh_ff[PER_W-1] ? SCL_W'(mag_ff) : '0);
         per_sh_ff <= {per_sh_ff[PER_W-2:0], 1'b0};
      end else if (cmd.div_step) begin
         rem_ff  <= q_bit ? LEN_W'(rem_sh - {1'b0, ped_len}) : rem_sh[LEN_W-1:0];
         work_ff <= {work_ff[SCL_W-2:0], q_bit};
      end
   end

   // The area has the opposite sign of the difference; saturate to the result range.
   assign over = |work_ff[SCL_W-1:AREA_W-1];
   always_comb begin
      if (neg_ff) begin
         area_w = over ? {1'b0, {(AREA_W-1){1'b1}}} : $signed(work_ff[AREA_W-1:0]);
      end else begin
         area_w = over ? {1'b1, {(AREA_W-1){1'b0}}} : -$signed(work_ff[AREA_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_pulse_area_ff    <= area_w;
         rsp_pedestal_used_ff <= use_ped;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pulse_area    = rsp_pulse_area_ff;
   assign rsp_pedestal_used = rsp_pedestal_used_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   // The sums are cleared in the same edge that captures the result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (sample_index_ff == '0) && (integ_accum_ff == '0)
                       && (ped_accum_ff == '0))
      else $error("waveform state not cleared after result");

   assert property (@(posedge clock) disable iff (reset)
      sample_index_ff <= DEPTH_IDX)
      else $error("sample index beyond depth");
`endif

endmodule

### src/pulse_integrator_pedestal_sub_unit.sv
`timescale 1ns / 1ps
// Pulse integrator with pedestal subtraction.
// Input: one waveform sample per item on req_sample, taken at a clock edge with start
// high and busy low; req_last_sample marks the final sample of the waveform. Samples are
// taken one per cycle, with busy low, until the final one.
// Two windows, set through the csr registers, select the samples summed as the
// integral and as the pedestal. After the final sample busy rises and a sequencer
// forms -(intsum*pedlen - pedsum*intlen) * period / pedlen with a pedestal, or
// -intsum * period without one, rounded toward zero and saturated to 52 bits. Its
// steps are the cross products, the difference, shift-add scaling by the sample
// period, then restoring division by the pedestal length when a pedestal is used.
// Busy stays high until the cycle the result is shown. Each result is shown for one cycle
// with rsp_valid high; the receiver cannot stall it.
// Reset clears the sums and the sample index and loads the register defaults: full
// integration window, no pedestal, 500 ps sample period. Registers may be written only
// while no waveform is in progress.
module pulse_integrator_pedestal_sub_unit (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic signed [pip_sub_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                       req_last_sample,
   output logic                                       rsp_valid,
   output logic signed [pip_sub_pkg::AREA_W-1:0]      rsp_pulse_area,
   output logic                                       rsp_pedestal_used,
   input  logic                                       psel,
   input  logic                                       penable,
   input  logic                                       pwrite,
   input  logic [pip_sub_pkg::ADDR_W-1:0]             paddr,
   input  logic [pip_sub_pkg::DATA_W-1:0]             pwdata,
   output logic [pip_sub_pkg::DATA_W-1:0]             prdata,
   output logic                                       pready
);
   import pip_sub_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   logic    use_ped;

   pip_sub_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pip_sub_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_last_sample (req_last_sample),
      .use_ped         (use_ped),
      .busy            (busy),
      .cmd             (cmd)
   );

   pip_sub_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .req_sample        (req_sample),
      .use_ped           (use_ped),
      .rsp_valid         (rsp_valid),
      .rsp_pulse_area    (rsp_pulse_area),
      .rsp_pedestal_used (rsp_pedestal_used)
   );

endmodule
